// ----- src/rss_pkg.sv -----
// Shared types, function codes and constants of the retransmit slot scheduler.
// No dependencies.

package rss_pkg;

	localparam int NUM_SLOTS_DEF = 3;

	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_ADD    = 3'd1;
	localparam logic [2:0] FN_CANCEL = 3'd2;
	localparam logic [2:0] FN_QACK   = 3'd3;
	localparam logic [2:0] FN_RXACK  = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_EMPTY   = 2'd1;
	localparam logic [1:0] ST_BAD_ACK = 2'd2;

	localparam logic [7:0] ACK_FLAG  = 8'h80;
	localparam logic [7:0] ACK_LEN   = 8'h01;
	localparam logic [7:0] RX_CMD0   = 8'h81;
	localparam logic [7:0] RX_CMD1   = 8'h82;
	localparam logic [6:0] RX_CODE_A = 7'h02;
	localparam logic [6:0] RX_CODE_B = 7'h03;

	typedef struct packed {
		logic [2:0] func;
		logic [1:0] slot;
		logic [7:0] send_limit;
		logic [7:0] timeout_ticks;
		logic       delayed_start;
		logic [6:0] ack_code;
		logic [7:0] cmd_byte;
		logic       link_online;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       send_valid;
		logic       send_is_ack;
		logic [1:0] send_slot;
		logic       slot_gave_up;
		logic [7:0] ack_byte;
		logic [7:0] ack_cmd;
		logic [7:0] ack_checksum;
	} rsp_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic step;
		logic load_out;
	} ctl_t;

	typedef struct packed {
		logic [2:0] func;
		logic       online;
		logic       ack_pending;
		logic       step_hit;
		logic       idx_last;
	} sts_t;

endpackage

// ----- src/rss_ctrl.sv -----
// Sequencer of the retransmit slot scheduler: input handshake, op dispatch, slot walk,
// output register handshake. Depends on rss_pkg.

module rss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	input  rss_pkg::sts_t sts,
	output rss_pkg::ctl_t ctl
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_in = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.func == rss_pkg::FN_TICK && sts.online && !sts.ack_pending) begin
					state_d = S_WALK;
				end else begin
					ctl.exec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_WALK: begin
				ctl.step = 1'b1;
				if (sts.step_hit || sts.idx_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					ctl.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- src/rss_datapath.sv -----
// Slot table, pending ack frame, walk index and result registers of the scheduler.
// Depends on rss_pkg; driven by rss_ctrl commands.

module rss_datapath #(
	parameter int NUM_SLOTS = rss_pkg::NUM_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rss_pkg::req_t req,
	output rss_pkg::rsp_t rsp,
	input  rss_pkg::ctl_t ctl,
	output rss_pkg::sts_t sts
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);

	rss_pkg::req_t     in_q;
	rss_pkg::rsp_t     res_q;
	rss_pkg::rsp_t     out_q;
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] idx_d;

	logic [NUM_SLOTS-1:0] active_q;
	logic [7:0]           timer_q   [NUM_SLOTS];
	logic [7:0]           timeout_q [NUM_SLOTS];
	logic [7:0]           sent_q    [NUM_SLOTS];
	logic [7:0]           limit_q   [NUM_SLOTS];

	logic       ack_pend_q;
	logic [7:0] ack_stat_q;
	logic [7:0] ack_cmd_q;
	logic [7:0] ack_sum_q;

	logic       cur_active;
	logic [7:0] cur_timer;
	logic [7:0] cur_timeout;
	logic [7:0] cur_sent;
	logic [7:0] cur_limit;
	logic [7:0] sent_nxt;
	logic [7:0] qack_stat;
	logic       slot_ok;
	logic       rx_ok;
	logic       expired;
	logic       hit;
	logic       gave_up;
	logic       add_en;
	logic       clr_en;
	logic       ack_send;
	logic       qack_en;

	always_comb begin
		cur_active  = active_q[idx_q];
		cur_timer   = timer_q[idx_q];
		cur_timeout = timeout_q[idx_q];
		cur_sent    = sent_q[idx_q];
		cur_limit   = limit_q[idx_q];
		sent_nxt    = cur_sent + 8'd1;
		qack_stat   = {1'b0, in_q.ack_code} | rss_pkg::ACK_FLAG;
		slot_ok     = ({3'b000, in_q.slot} < 5'(NUM_SLOTS));
		rx_ok       = (in_q.cmd_byte == rss_pkg::RX_CMD0 || in_q.cmd_byte == rss_pkg::RX_CMD1)
			&& (in_q.ack_code == rss_pkg::RX_CODE_A || in_q.ack_code == rss_pkg::RX_CODE_B);
		expired     = cur_active && !(cur_timer < cur_timeout);
		hit         = expired && (cur_sent < cur_limit);
		gave_up     = !(sent_nxt < cur_limit);
		add_en      = ctl.exec && in_q.func == rss_pkg::FN_ADD && slot_ok;
		clr_en      = ctl.exec && cur_active
			&& ((in_q.func == rss_pkg::FN_CANCEL && slot_ok)
			|| (in_q.func == rss_pkg::FN_RXACK && rx_ok));
		ack_send    = ctl.exec && in_q.func == rss_pkg::FN_TICK && in_q.link_online && ack_pend_q;
		qack_en     = ctl.exec && in_q.func == rss_pkg::FN_QACK;

		if (req.func == rss_pkg::FN_RXACK) begin
			idx_d = (req.cmd_byte == rss_pkg::RX_CMD1) ? SLOT_W'(1) : '0;
		end else if (req.func == rss_pkg::FN_ADD || req.func == rss_pkg::FN_CANCEL) begin
			idx_d = SLOT_W'(req.slot);
		end else begin
			idx_d = '0;
		end

		sts.func        = in_q.func;
		sts.online      = in_q.link_online;
		sts.ack_pending = ack_pend_q;
		sts.step_hit    = hit;
		sts.idx_last    = (idx_q == SLOT_W'(NUM_SLOTS - 1));
	end

	assign rsp = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			ack_pend_q <= 1'b0;
		end else begin
			if (add_en) begin
				active_q[idx_q] <= 1'b1;
			end else if (clr_en) begin
				active_q[idx_q] <= 1'b0;
			end else if (ctl.step && hit && gave_up) begin
				active_q[idx_q] <= 1'b0;
			end
			if (qack_en) begin
				ack_pend_q <= 1'b1;
			end else if (ack_send) begin
				ack_pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			in_q <= req;
			idx_q <= idx_d;
			res_q <= '0;
		end
		if (ctl.load_out) begin
			out_q <= res_q;
		end
		if (add_en) begin
			timer_q[idx_q] <= in_q.delayed_start ? 8'd0 : in_q.timeout_ticks;
			timeout_q[idx_q] <= in_q.timeout_ticks;
			limit_q[idx_q] <= in_q.send_limit;
			sent_q[idx_q] <= 8'd0;
		end
		if (clr_en) begin
			timer_q[idx_q] <= 8'd0;
			timeout_q[idx_q] <= 8'd0;
			sent_q[idx_q] <= 8'd0;
		end
		if (qack_en) begin
			ack_stat_q <= qack_stat;
			ack_cmd_q <= in_q.cmd_byte;
			ack_sum_q <= ~(qack_stat + rss_pkg::ACK_LEN + in_q.cmd_byte);
		end
		if (ctl.exec) begin
			case (in_q.func)
				rss_pkg::FN_CANCEL: begin
					if (!slot_ok || !cur_active) begin
						res_q.status <= rss_pkg::ST_EMPTY;
					end
				end
				rss_pkg::FN_RXACK: begin
					if (!rx_ok) begin
						res_q.status <= rss_pkg::ST_BAD_ACK;
					end
				end
				default: begin
				end
			endcase
			if (ack_send) begin
				res_q.send_valid <= 1'b1;
				res_q.send_is_ack <= 1'b1;
				res_q.ack_byte <= ack_stat_q;
				res_q.ack_cmd <= ack_cmd_q;
				res_q.ack_checksum <= ack_sum_q;
			end
		end
		if (ctl.step) begin
			idx_q <= idx_q + SLOT_W'(1);
			if (cur_active) begin
				if (!expired) begin
					timer_q[idx_q] <= cur_timer + 8'd1;
				end else begin
					timer_q[idx_q] <= 8'd0;
					if (hit) begin
						res_q.send_valid <= 1'b1;
						res_q.send_slot <= 2'(idx_q);
						if (gave_up) begin
							sent_q[idx_q] <= 8'd0;
							limit_q[idx_q] <= 8'd0;
							res_q.slot_gave_up <= 1'b1;
						end else begin
							sent_q[idx_q] <= sent_nxt;
						end
					end
				end
			end
		end
	end

endmodule

// ----- src/retransmit_slot_scheduler_core.sv -----
// Top level of the retransmit slot scheduler: sequencer plus slot datapath.
// Depends on rss_pkg, rss_ctrl and rss_datapath.

// One beat in gives one beat out. Add, cancel, queue-ack, ack-received, unused codes, an
// offline tick and a tick that sends a pending ack pass through execute and finish before
// the next beat is accepted; a tick that walks the slot table also visits k (1 to NUM_SLOTS)
// slots in a walk state, one per cycle, up to and including the first one that sends.
// The walk examines slots one at a time through a single read port on the slot table.
// A finished result waits in the output register while the next beat is accepted.

module retransmit_slot_scheduler_core #(
	parameter int NUM_SLOTS = rss_pkg::NUM_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rss_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rss_pkg::rsp_t rsp
);

	rss_pkg::ctl_t ctl;
	rss_pkg::sts_t sts;

	rss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	rss_datapath #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.ctl    (ctl),
		.sts    (sts)
	);

endmodule

// ----- tb/sv/retransmit_slot_scheduler_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for retransmit_slot_scheduler_core: a scoreboard class predicts
// each result beat from the request stream, while a task and a process drive both channels with stalls.
// Depends on rss_pkg and the retransmit_slot_scheduler_core RTL.

import rss_pkg::*;

localparam int SLOT_COUNT = NUM_SLOTS_DEF;
localparam logic [2:0] FN_SPARE_LO = 3'd5;
localparam logic [2:0] FN_SPARE_HI = 3'd7;

class outcome_board;
	rsp_t outcome_q[$];
	bit armed [SLOT_COUNT];
	logic [7:0] timer [SLOT_COUNT];
	logic [7:0] timeout [SLOT_COUNT];
	logic [7:0] sent [SLOT_COUNT];
	logic [7:0] limit [SLOT_COUNT];
	bit gave_up [SLOT_COUNT];
	bit ack_waiting;
	logic [7:0] ack_status;
	logic [7:0] ack_cmd;
	logic [7:0] ack_sum;
	int mismatches;
	int checked;
	int slot_sends;
	int ack_sends;
	int give_ups;
	int error_status;

	function void clear_state();
		for (int i = 0; i < SLOT_COUNT; i++) begin
			armed[i] = 0;
			timer[i] = '0;
			timeout[i] = '0;
			sent[i] = '0;
			limit[i] = '0;
			gave_up[i] = 0;
		end
		ack_waiting = 0;
		ack_status = '0;
		ack_cmd = '0;
		ack_sum = '0;
	endfunction

	function bit release_slot(int s);
		if (s >= SLOT_COUNT || !armed[s])
			return 1'b1;
		armed[s] = 0;
		timer[s] = '0;
		timeout[s] = '0;
		sent[s] = '0;
		return 1'b0;
	endfunction

	function void note_request(req_t r);
		rsp_t o;
		bit hit;
		o = '0;
		hit = 0;
		case (r.func)
			FN_TICK: if (r.link_online) begin
				if (ack_waiting) begin
					ack_waiting = 0;
					o.send_valid = 1'b1;
					o.send_is_ack = 1'b1;
					o.ack_byte = ack_status;
					o.ack_cmd = ack_cmd;
					o.ack_checksum = ack_sum;
					ack_sends++;
				end else begin
					for (int i = 0; i < SLOT_COUNT; i++) begin
						if (armed[i] && !hit) begin
							if (timer[i] < timeout[i]) begin
								timer[i] = timer[i] + 8'd1;
							end else begin
								timer[i] = '0;
								if (sent[i] < limit[i]) begin
									sent[i] = sent[i] + 8'd1;
									o.send_valid = 1'b1;
									o.send_slot = 2'(i);
									hit = 1;
									slot_sends++;
									if (sent[i] >= limit[i]) begin
										armed[i] = 0;
										sent[i] = '0;
										limit[i] = '0;
										gave_up[i] = 1;
										o.slot_gave_up = 1'b1;
										give_ups++;
									end
								end
							end
						end
					end
				end
			end
			FN_ADD: if (r.slot < SLOT_COUNT) begin
				timer[r.slot] = r.delayed_start ? 8'd0 : r.timeout_ticks;
				timeout[r.slot] = r.timeout_ticks;
				limit[r.slot] = r.send_limit;
				sent[r.slot] = '0;
				armed[r.slot] = 1;
			end
			FN_CANCEL: o.status = release_slot(r.slot) ? ST_EMPTY : ST_OK;
			FN_QACK: begin
				ack_status = {1'b1, r.ack_code};
				ack_cmd = r.cmd_byte;
				ack_sum = ~(ack_status + ACK_LEN + r.cmd_byte);
				ack_waiting = 1;
			end
			FN_RXACK: begin
				if ((r.cmd_byte != RX_CMD0 && r.cmd_byte != RX_CMD1) ||
				    (r.ack_code != RX_CODE_A && r.ack_code != RX_CODE_B))
					o.status = ST_BAD_ACK;
				else
					void'(release_slot(r.cmd_byte == RX_CMD0 ? 0 : 1));
			end
			default: ;
		endcase
		if (o.status != ST_OK)
			error_status++;
		outcome_q.push_back(o);
	endfunction

	function void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_response(rsp_t got);
		rsp_t want;
		if (outcome_q.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
			mismatches++;
			return;
		end
		want = outcome_q.pop_front();
		checked++;
		compare_field("status", 8'(want.status), 8'(got.status));
		compare_field("send_valid", 8'(want.send_valid), 8'(got.send_valid));
		compare_field("send_is_ack", 8'(want.send_is_ack), 8'(got.send_is_ack));
		compare_field("send_slot", 8'(want.send_slot), 8'(got.send_slot));
		compare_field("slot_gave_up", 8'(want.slot_gave_up), 8'(got.slot_gave_up));
		compare_field("ack_byte", want.ack_byte, got.ack_byte);
		compare_field("ack_cmd", want.ack_cmd, got.ack_cmd);
		compare_field("ack_checksum", want.ack_checksum, got.ack_checksum);
	endfunction

	function int outstanding();
		return outcome_q.size();
	endfunction
endclass

module retransmit_slot_scheduler_core_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_BEATS = 210;
	localparam int DRAIN_CYCLES = 16;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	outcome_board board;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_req;
	int cycles;
	int beats_in;

	retransmit_slot_scheduler_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic req_t make_req(logic [2:0] fn, logic [1:0] s, logic [7:0] lim,
		logic [7:0] tmo, logic dly, logic [6:0] code, logic [7:0] cmd, logic online);
		req_t r;
		r.func = fn;
		r.slot = s;
		r.send_limit = lim;
		r.timeout_ticks = tmo;
		r.delayed_start = dly;
		r.ack_code = code;
		r.cmd_byte = cmd;
		r.link_online = online;
		return r;
	endfunction

	function automatic req_t random_req();
		req_t r;
		logic [63:0] raw;
		int pick;
		raw = {$urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		pick = $urandom_range(0, 99);
		r.link_online = ($urandom_range(0, 9) != 0);
		if (pick < 42) begin
			r.func = FN_TICK;
		end else if (pick < 58) begin
			r.func = FN_ADD;
			r.slot = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, SLOT_COUNT - 1));
			if ($urandom_range(0, 7) != 0) begin
				r.send_limit = 8'($urandom_range(0, 5));
				r.timeout_ticks = 8'($urandom_range(0, 4));
			end
		end else if (pick < 68) begin
			r.func = FN_CANCEL;
		end else if (pick < 80) begin
			r.func = FN_QACK;
		end else if (pick < 94) begin
			r.func = FN_RXACK;
			if ($urandom_range(0, 9) < 7) begin
				r.cmd_byte = $urandom_range(0, 1) ? RX_CMD1 : RX_CMD0;
				r.ack_code = $urandom_range(0, 1) ? RX_CODE_B : RX_CODE_A;
			end
		end else begin
			r.func = 3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
		end
		return r;
	endfunction

	// Entered and left at a falling edge.
	task automatic drive_beat(input req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (req_stall);
		board.note_request(r);
		beats_in++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (board.outstanding() != 0)
			@(negedge clk);
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				hold_left = 120;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
			end
			@(posedge clk);
			if (rsp_valid && !rsp_stall)
				board.check_response(rsp);
		end
	end

	initial begin
		req_t directed_q[$];
		board = new();
		board.clear_state();
		beats_in = 0;
		hold_req = 0;
		send_idle_pct = 27;
		recv_idle_pct = 75;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b0));
		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_CANCEL, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_CANCEL, 2'd3, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_ADD, 2'd3, 8'd4, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_ADD, 2'd0, 8'd2, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_ADD, 2'd1, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_ADD, 2'd2, 8'hff, 8'hff, 1'b1, 7'h7f, 8'hff, 1'b1));
		directed_q.push_back(make_req(FN_TICK, 2'd3, 8'hff, 8'hff, 1'b1, 7'h7f, 8'hff, 1'b1));
		directed_q.push_back(make_req(FN_QACK, 2'd0, 8'd0, 8'd0, 1'b0, 7'h7f, 8'hff, 1'b1));
		directed_q.push_back(make_req(FN_QACK, 2'd0, 8'd0, 8'd0, 1'b0, 7'h00, 8'h00, 1'b0));
		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b0));
		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_RXACK, 2'd0, 8'd0, 8'd0, 1'b0, RX_CODE_A, RX_CMD0, 1'b1));
		directed_q.push_back(make_req(FN_RXACK, 2'd0, 8'd0, 8'd0, 1'b0, RX_CODE_B, RX_CMD1, 1'b1));
		directed_q.push_back(make_req(FN_RXACK, 2'd0, 8'd0, 8'd0, 1'b0, RX_CODE_A, 8'h80, 1'b1));
		directed_q.push_back(make_req(FN_RXACK, 2'd0, 8'd0, 8'd0, 1'b0, 7'h7f, RX_CMD0, 1'b1));
		directed_q.push_back(make_req(FN_SPARE_LO, 2'd3, 8'hff, 8'hff, 1'b1, 7'h7f, 8'hff, 1'b1));
		directed_q.push_back(make_req(3'd6, 2'd3, 8'hff, 8'hff, 1'b1, 7'h7f, 8'hff, 1'b1));
		directed_q.push_back(make_req(FN_SPARE_HI, 2'd3, 8'hff, 8'hff, 1'b1, 7'h7f, 8'hff, 1'b1));
		directed_q.push_back(make_req(FN_ADD, 2'd2, 8'd1, 8'd1, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_TICK, 2'd0, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		directed_q.push_back(make_req(FN_CANCEL, 2'd2, 8'd0, 8'd0, 1'b0, 7'd0, 8'd0, 1'b1));
		foreach (directed_q[i])
			drive_beat(directed_q[i]);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 75 : 0;
			recv_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 27 : 0;
			if (phase == 1)
				drain_results();
			for (int n = 0; n < RANDOM_BEATS; n++) begin
				if (phase == 0 && n == 100)
					hold_req = 1;
				drive_beat(random_req());
			end
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("%0d request beats, %0d results checked, %0d mismatches",
			beats_in, board.checked, board.mismatches);
		$display("%0d slot sends, %0d give-ups, %0d ack sends, %0d error statuses",
			board.slot_sends, board.give_ups, board.ack_sends, board.error_status);
		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- files.f -----
src/rss_pkg.sv
src/rss_ctrl.sv
src/rss_datapath.sv
src/retransmit_slot_scheduler_core.sv
tb/sv/retransmit_slot_scheduler_core_tb.sv
